@@ sv/kfl_pkg.sv @@
// shared types and constants of the keyframe position interpolation core
`default_nettype none

package kfl_pkg;

    localparam int KFL_MAX_KEYS  = 64;
    localparam int KFL_FRAC_BITS = 16;
    localparam int KFL_TIME_W    = 32;
    localparam int KFL_POS_W     = 32;

    typedef enum logic [2:0] {
        ACT_APPEND = 3'd0,
        ACT_CLEAR  = 3'd1,
        ACT_PLAY   = 3'd2,
        ACT_PAUSE  = 3'd3,
        ACT_STOP   = 3'd4,
        ACT_TICK   = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK_FIRST,
        ST_CHK_LAST,
        ST_SCAN,
        ST_DIV,
        ST_MUL,
        ST_ACC
    } t_state;

    typedef struct packed {
        logic        [2:0]           action;
        logic        [KFL_TIME_W-1:0] key_time;
        logic        [KFL_TIME_W-1:0] delta_time;
        logic signed [KFL_POS_W-1:0]  key_x;
        logic signed [KFL_POS_W-1:0]  key_y;
        logic signed [KFL_POS_W-1:0]  key_z;
    } t_in_item;

    typedef struct packed {
        logic signed [KFL_POS_W-1:0] out_x;
        logic signed [KFL_POS_W-1:0] out_y;
        logic signed [KFL_POS_W-1:0] out_z;
    } t_out_item;

    typedef struct packed {
        logic        [KFL_TIME_W-1:0] key_time;
        logic signed [KFL_POS_W-1:0]  x;
        logic signed [KFL_POS_W-1:0]  y;
        logic signed [KFL_POS_W-1:0]  z;
    } t_key;

    typedef struct packed {
        logic                  start;
        logic [KFL_TIME_W-1:0] num;
        logic [KFL_TIME_W-1:0] den;
    } t_div_req;

endpackage

`default_nettype wire

@@ sv/kfl_key_mem.sv @@
// keyframe table, one write port and one registered read port
`default_nettype none

module kfl_key_mem
    import kfl_pkg::*;
#(
    parameter int DEPTH = KFL_MAX_KEYS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_key          i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output t_key               o_rdata
);

    t_key r_mem [DEPTH];
    t_key r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sv/kfl_div.sv @@
// iterative restoring divider for the segment fraction
`default_nettype none

module kfl_div
    import kfl_pkg::*;
#(
    parameter int FRAC_BITS = KFL_FRAC_BITS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_div_req         i_req,
    output logic                  o_done,
    output logic [FRAC_BITS:0]    o_quot
);

    localparam int CNTW = $clog2(FRAC_BITS + 2);
    localparam int RW   = KFL_TIME_W + 1;

    logic            r_run,  n_run;
    logic            r_done, n_done;
    logic [CNTW-1:0] r_cnt,  n_cnt;
    logic [RW-1:0]   r_rem,  n_rem;
    logic [KFL_TIME_W-1:0] r_den, n_den;
    logic [FRAC_BITS:0]    r_quot, n_quot;
    logic [RW-1:0]   diff;
    logic            ge;

    assign ge   = r_rem >= {1'b0, r_den};
    assign diff = r_rem - {1'b0, r_den};

    always_comb begin
        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quot = r_quot;
        if (i_req.start) begin
            n_run  = 1'b1;
            n_cnt  = CNTW'(FRAC_BITS + 1);
            n_rem  = {1'b0, i_req.num};
            n_den  = i_req.den;
            n_quot = '0;
        end else if (r_run) begin
            n_quot = {r_quot[FRAC_BITS-1:0], ge};
            n_rem  = ge ? {diff[RW-2:0], 1'b0} : {r_rem[RW-2:0], 1'b0};
            n_cnt  = r_cnt - CNTW'(1);
            if (r_cnt == CNTW'(1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

@@ sv/keyframe_position_lerp_core.sv @@
// keyframe position track player with linear interpolation
// append, clear, play, pause, stop and ticks without a result finish in the idle state, busy stays low
// a tick clamped to the first or last key strobes its result after the first- or last-key check state
// an interpolated tick runs the key walk, the divide, then a multiply and an accumulate step per axis
// the walk reads one key per cycle, the divide one bit per cycle; the receiver cannot stall
// reset clears the key count, track time and play flag; the table itself is not cleared
`default_nettype none

module keyframe_position_lerp_core
    import kfl_pkg::*;
#(
    parameter int MAX_KEYS  = KFL_MAX_KEYS,
    parameter int FRAC_BITS = KFL_FRAC_BITS
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire t_in_item  i_item,
    output logic           o_valid,
    output t_out_item      o_item
);

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int PW = KFL_POS_W + FRAC_BITS + 3;
    localparam int TW = KFL_TIME_W;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [TW-1:0] r_time,  n_time;
    logic          r_playing, n_playing;
    logic          r_valid, n_valid;
    t_out_item     r_out, n_out;
    t_key          r_prev, n_prev;
    t_key          r_cur,  n_cur;
    logic [AW-1:0] r_idx,  n_idx;
    logic [1:0]    r_k,    n_k;
    logic [FRAC_BITS:0]  r_f, n_f;
    logic signed [PW-1:0] r_prod, n_prod;

    logic          accept;
    logic          mem_we;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] last;
    t_key          wr_key;
    t_key          rd_key;
    t_div_req      div_req;
    logic          div_done;
    logic [FRAC_BITS:0] div_quot;
    logic [TW:0]   time_sum;
    logic          match;
    logic          flat;
    logic          room;
    logic signed [KFL_POS_W-1:0] coord_a, coord_b, coord_sum;
    logic signed [KFL_POS_W:0]   coord_d;

    function automatic logic signed [KFL_POS_W-1:0] key_coord(t_key k, logic [1:0] sel);
        logic signed [KFL_POS_W-1:0] v;
        case (sel)
            2'd0:    v = k.x;
            2'd1:    v = k.y;
            default: v = k.z;
        endcase
        return v;
    endfunction

    assign accept   = start && !busy;
    assign busy     = r_state != ST_IDLE;
    assign last     = AW'(r_count - CW'(1));
    assign room     = r_count < CW'(MAX_KEYS);
    assign mem_we   = accept && (i_item.action == ACT_APPEND) && room;
    assign time_sum = {1'b0, r_time} + {1'b0, i_item.delta_time};
    assign match    = (r_time >= r_prev.key_time) && (r_time <= rd_key.key_time);
    assign flat     = rd_key.key_time == r_prev.key_time;

    assign wr_key.key_time = i_item.key_time;
    assign wr_key.x        = i_item.key_x;
    assign wr_key.y        = i_item.key_y;
    assign wr_key.z        = i_item.key_z;

    assign coord_a   = key_coord(r_prev, r_k);
    assign coord_b   = key_coord(r_cur, r_k);
    assign coord_d   = {coord_b[KFL_POS_W-1], coord_b} - {coord_a[KFL_POS_W-1], coord_a};
    assign coord_sum = coord_a + r_prod[FRAC_BITS +: KFL_POS_W];

    kfl_key_mem #(
        .DEPTH(MAX_KEYS),
        .AW   (AW)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(wr_key),
        .i_raddr(rd_addr),
        .o_rdata(rd_key)
    );

    kfl_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_done (div_done),
        .o_quot (div_quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_item.action == ACT_TICK) && r_playing && (r_count != '0)) begin
                    n_state = ST_CHK_FIRST;
                end
            end
            ST_CHK_FIRST: begin
                if ((r_count == CW'(1)) || (r_time <= rd_key.key_time)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_CHK_LAST;
                end
            end
            ST_CHK_LAST: begin
                n_state = (r_time >= rd_key.key_time) ? ST_IDLE : ST_SCAN;
            end
            ST_SCAN: begin
                if (match) begin
                    n_state = flat ? ST_IDLE : ST_DIV;
                end else if (r_idx == last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_state = (r_k == 2'd2) ? ST_IDLE : ST_MUL;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_count   = r_count;
        n_time    = r_time;
        n_playing = r_playing;
        n_valid   = 1'b0;
        n_out     = r_out;
        n_prev    = r_prev;
        n_cur     = r_cur;
        n_idx     = r_idx;
        n_k       = r_k;
        n_f       = r_f;
        n_prod    = r_prod;
        rd_addr   = '0;
        div_req.start = 1'b0;
        div_req.num   = r_time - r_prev.key_time;
        div_req.den   = rd_key.key_time - r_prev.key_time;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (t_action'(i_item.action))
                        ACT_APPEND: begin
                            if (room) begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        ACT_CLEAR: begin
                            n_count = '0;
                        end
                        ACT_PLAY: begin
                            n_playing = 1'b1;
                            n_time    = '0;
                        end
                        ACT_PAUSE: begin
                            n_playing = 1'b0;
                        end
                        ACT_STOP: begin
                            n_playing = 1'b0;
                            n_time    = '0;
                        end
                        ACT_TICK: begin
                            if (r_playing) begin
                                n_time = time_sum[TW] ? '1 : time_sum[TW-1:0];
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CHK_FIRST: begin
                rd_addr = last;
                n_prev  = rd_key;
                if ((r_count == CW'(1)) || (r_time <= rd_key.key_time)) begin
                    n_valid = 1'b1;
                    n_out   = '{rd_key.x, rd_key.y, rd_key.z};
                end
            end
            ST_CHK_LAST: begin
                rd_addr = AW'(1);
                n_idx   = AW'(1);
                if (r_time >= rd_key.key_time) begin
                    n_valid = 1'b1;
                    n_out   = '{rd_key.x, rd_key.y, rd_key.z};
                end
            end
            ST_SCAN: begin
                rd_addr = r_idx + AW'(1);
                if (match) begin
                    n_cur = rd_key;
                    if (flat) begin
                        n_valid = 1'b1;
                        n_out   = '{r_prev.x, r_prev.y, r_prev.z};
                    end else begin
                        div_req.start = 1'b1;
                    end
                end else if (r_idx == last) begin
                    n_valid = 1'b1;
                    n_out   = '{rd_key.x, rd_key.y, rd_key.z};
                end else begin
                    n_prev = rd_key;
                    n_idx  = r_idx + AW'(1);
                end
            end
            ST_DIV: begin
                n_f = div_quot;
                n_k = 2'd0;
            end
            ST_MUL: begin
                n_prod = PW'(coord_d) * PW'($signed({1'b0, r_f}));
            end
            ST_ACC: begin
                case (r_k)
                    2'd0:    n_out.out_x = coord_sum;
                    2'd1:    n_out.out_y = coord_sum;
                    default: n_out.out_z = coord_sum;
                endcase
                n_k = r_k + 2'd1;
                if (r_k == 2'd2) begin
                    n_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_time    <= '0;
            r_playing <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_time    <= n_time;
            r_playing <= n_playing;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_prev <= n_prev;
        r_cur  <= n_cur;
        r_idx  <= n_idx;
        r_k    <= n_k;
        r_f    <= n_f;
        r_prod <= n_prod;
    end

    assign o_valid = r_valid;
    assign o_item  = r_out;

    a_valid_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ($past(r_state) != ST_IDLE))
        else $error("result strobe without a tick in progress");

    a_quiet_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_item.action == ACT_TICK) && (!r_playing || (r_count == '0)))
        |=> (r_state == ST_IDLE) && !r_valid)
        else $error("tick without result left the core busy");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_KEYS))
        else $error("key count beyond table depth");

    a_div_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide step");

endmodule

`default_nettype wire

@@ sim/tb_keyframe_position_lerp_core.sv @@
// testbench for the keyframe position track player: random and directed commands, scoreboarded
`timescale 1ns / 100ps

module tb_keyframe_position_lerp_core;
    import kfl_pkg::*;

    class position_scoreboard;
        t_key        keys[KFL_MAX_KEYS];
        int unsigned key_total;
        logic [31:0] play_time;
        bit          running;
        t_out_item   pending_positions[$];
        int unsigned mismatches;
        int unsigned positions_checked;
        int unsigned appends_dropped;
        int unsigned time_saturations;
        int unsigned largest_track;

        function new();
            key_total = 0;
            play_time = '0;
            running = 1'b0;
            mismatches = 0;
            positions_checked = 0;
            appends_dropped = 0;
            time_saturations = 0;
            largest_track = 0;
        endfunction

        task report_mismatch(input string msg);
            $display("ERROR at %0t: %s", $time, msg);
            mismatches++;
        endtask

        function t_out_item key_position(input int unsigned idx);
            t_out_item r;
            r.out_x = keys[idx].x;
            r.out_y = keys[idx].y;
            r.out_z = keys[idx].z;
            return r;
        endfunction

        function logic [31:0] lerp_axis(input logic signed [31:0] a,
                                        input logic signed [31:0] b,
                                        input longint f);
            longint d;
            longint p;
            d = longint'(b) - longint'(a);
            p = d * f;
            return 32'(longint'(a) + (p >>> KFL_FRAC_BITS));
        endfunction

        function t_out_item position_at_time(input logic [31:0] t);
            int unsigned last;
            int unsigned idx;
            logic [31:0] dt;
            longint      span;
            longint      f;
            t_out_item   r;
            last = key_total - 1;
            if (key_total == 1 || t <= keys[0].key_time) return key_position(0);
            if (t >= keys[last].key_time) return key_position(last);
            for (idx = 0; idx < last; idx++) begin
                if (t >= keys[idx].key_time && t <= keys[idx + 1].key_time) begin
                    span = {32'd0, keys[idx + 1].key_time} - {32'd0, keys[idx].key_time};
                    if (span == 0) return key_position(idx);
                    dt = t - keys[idx].key_time;
                    f = ({32'd0, dt} << KFL_FRAC_BITS) / span;
                    r.out_x = lerp_axis(keys[idx].x, keys[idx + 1].x, f);
                    r.out_y = lerp_axis(keys[idx].y, keys[idx + 1].y, f);
                    r.out_z = lerp_axis(keys[idx].z, keys[idx + 1].z, f);
                    return r;
                end
            end
            return key_position(last);
        endfunction

        function void note_command(input t_in_item it);
            logic [32:0] sum;
            case (it.action)
                ACT_APPEND: begin
                    if (key_total < KFL_MAX_KEYS) begin
                        keys[key_total].key_time = it.key_time;
                        keys[key_total].x = it.key_x;
                        keys[key_total].y = it.key_y;
                        keys[key_total].z = it.key_z;
                        key_total++;
                        if (key_total > largest_track) largest_track = key_total;
                    end else begin
                        appends_dropped++;
                    end
                end
                ACT_CLEAR: key_total = 0;
                ACT_PLAY: begin
                    running = 1'b1;
                    play_time = '0;
                end
                ACT_PAUSE: running = 1'b0;
                ACT_STOP: begin
                    running = 1'b0;
                    play_time = '0;
                end
                ACT_TICK: begin
                    if (running) begin
                        sum = {1'b0, play_time} + {1'b0, it.delta_time};
                        if (sum[32]) time_saturations++;
                        play_time = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                        if (key_total != 0)
                            pending_positions = {pending_positions,
                                                 position_at_time(play_time)};
                    end
                end
                default: ;
            endcase
        endfunction

        task check_position(input t_out_item got);
            t_out_item want;
            positions_checked++;
            if (pending_positions.size() == 0) begin
                report_mismatch($sformatf("position %h with none expected", got));
                return;
            end
            want = pending_positions.pop_front();
            if (got.out_x !== want.out_x)
                report_mismatch($sformatf("x got %h expected %h", got.out_x, want.out_x));
            if (got.out_y !== want.out_y)
                report_mismatch($sformatf("y got %h expected %h", got.out_y, want.out_y));
            if (got.out_z !== want.out_z)
                report_mismatch($sformatf("z got %h expected %h", got.out_z, want.out_z));
        endtask
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_item  i_item = '0;
    logic      o_valid;
    t_out_item o_item;

    position_scoreboard sb = new();
    int unsigned items_sent = 0;

    keyframe_position_lerp_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_position(o_item);
    end

    function automatic t_in_item make_command(input logic [2:0] act, input logic [31:0] kt,
                                              input logic [31:0] dt, input logic [31:0] x,
                                              input logic [31:0] y, input logic [31:0] z);
        t_in_item it;
        it.action = act;
        it.key_time = kt;
        it.delta_time = dt;
        it.key_x = x;
        it.key_y = y;
        it.key_z = z;
        return it;
    endfunction

    task automatic drive_item(input t_in_item it);
        while (!(items_sent >= 300 && items_sent < 420) && $urandom_range(0, 99) < 21) begin
            start <= 1'b0;
            i_item <= make_command(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
                                   $urandom, $urandom);
            @(posedge i_clk);
        end
        i_item <= it;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_command(it);
        items_sent++;
    endtask

    task automatic send_append(input logic [31:0] kt, input logic [31:0] x,
                               input logic [31:0] y, input logic [31:0] z);
        drive_item(make_command(ACT_APPEND, kt, $urandom, x, y, z));
    endtask

    task automatic send_tick(input logic [31:0] dt);
        drive_item(make_command(ACT_TICK, $urandom, dt, $urandom, $urandom, $urandom));
    endtask

    task automatic send_control(input logic [2:0] act);
        drive_item(make_command(act, $urandom, $urandom, $urandom, $urandom, $urandom));
    endtask

    task automatic wait_drained(input int settle);
        int guard;
        guard = 0;
        start <= 1'b0;
        while (sb.pending_positions.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (settle) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int          n_keys;
        int          n_ticks;
        int          episode;
        int          r;
        logic [31:0] t_next;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // tick before play, then tick on an empty track
        send_tick(32'd1);
        send_control(ACT_PLAY);
        send_tick(32'h0001_0000);
        // single key at the position extremes, then a second key and ticks along the track
        send_append(32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        send_tick(32'h0000_8000);
        send_append(32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_control(ACT_PLAY);
        send_tick(32'h0000_0000);
        send_tick(32'h0001_8000);
        send_tick(32'h0001_0000);
        // duplicate time, then a key out of order, then ticks, pause, unused actions, stop and play
        send_append(32'h0003_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003);
        send_append(32'h0000_8000, 32'hFFFB_0000, 32'h0123_4567, 32'h8000_0001);
        send_append(32'h0005_0000, 32'h0007_0000, 32'hFEDC_BA98, 32'h7FFF_FFFE);
        send_tick(32'h0000_8000);
        send_tick(32'h0001_0000);
        send_control(ACT_PAUSE);
        send_tick(32'h0001_0000);
        send_control(3'd6);
        send_control(3'd7);
        send_control(ACT_STOP);
        send_control(ACT_PLAY);
        // track time saturation, then clear and a tick on the empty track
        send_tick(32'hFFFF_FFFF);
        send_tick(32'hFFFF_FFFF);
        send_control(ACT_CLEAR);
        send_tick(32'd5);
        wait_drained(120);

        episode = 0;
        while (items_sent < 640) begin
            if (episode == 0 || $urandom_range(0, 99) < 85) send_control(ACT_CLEAR);
            if (episode == 0) n_keys = 66;
            else if ($urandom_range(0, 99) < 8) n_keys = $urandom_range(40, 70);
            else n_keys = $urandom_range(1, 6);
            t_next = $urandom_range(0, 32'h2_0000);
            repeat (n_keys) begin
                send_append(t_next, $urandom, $urandom, $urandom);
                r = $urandom_range(0, 99);
                if (r < 10) t_next = t_next;
                else if (r < 20) t_next = $urandom;
                else t_next = t_next + $urandom_range(1, 32'h3_0000);
            end
            send_control(ACT_PLAY);
            n_ticks = $urandom_range(3, 10);
            repeat (n_ticks) begin
                if ($urandom_range(0, 99) < 12)
                    drive_item(make_command(3'($urandom_range(0, 7)), $urandom, $urandom,
                                            $urandom, $urandom, $urandom));
                if ($urandom_range(0, 99) < 5) send_tick($urandom);
                else send_tick($urandom_range(0, 32'h2_0000));
            end
            episode++;
        end

        wait_drained(150);
        if (sb.pending_positions.size() != 0)
            sb.report_mismatch($sformatf("%0d positions never arrived",
                                         sb.pending_positions.size()));
        $display("%0d transactions in %0d track episodes, %0d positions checked",
                 items_sent, episode, sb.positions_checked);
        $display("largest track %0d keys, %0d appends dropped, %0d saturated ticks",
                 sb.largest_track, sb.appends_dropped, sb.time_saturations);
        if (sb.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
